@@ src/round_robin_request_dispatcher_macros.svh @@
// ----------------------------------------------------------------------------
// Round-robin request dispatcher assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_REQUEST_DISPATCHER_MACROS_SVH
`define ROUND_ROBIN_REQUEST_DISPATCHER_MACROS_SVH

// same-cycle implication
`define RRD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rrd_pkg.sv @@
// ----------------------------------------------------------------------------
// rrd_pkg
// Types and constants shared by the dispatcher controller and datapath.
// ----------------------------------------------------------------------------
package rrd_pkg;

    localparam int TIME_W    = 32;
    localparam int BUSY_W    = 33;
    localparam int COUNT_W   = 32;
    localparam int SRV_IDX_W = 6;
    localparam int NS_W      = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
    localparam logic [NS_W-1:0]    NUM_SERVERS_RESET = 7'd16;

    localparam logic OP_DISPATCH = 1'b0;
    localparam logic OP_REPORT   = 1'b1;

    localparam logic [0:0] REG_NUM_SERVERS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_EMIT,
        ST_RPT,
        ST_RFIN
    } ctrl_state_t;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] service_time;
    } req_item_t;

    typedef struct packed {
        logic                 served;
        logic [SRV_IDX_W-1:0] server_index;
        logic [COUNT_W-1:0]   busiest_count;
        logic                 last;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic disp_init;
        logic scan_step;
        logic rpt_step;
        logic emit_disp;
        logic emit_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_op;
        logic mod_done;
        logic hit;
        logic miss;
        logic rpt_match;
        logic rpt_last;
        logic pend_vld;
        logic out_space;
    } dp_status_t;

endpackage

@@ src/rrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrd_ctrl
// Sequencer for dispatch scans and busiest-server reports.
// ----------------------------------------------------------------------------
module rrd_ctrl
    import rrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rpt_go;

    // a report step waits while a held match cannot be pushed out
    assign rpt_go = !(st.rpt_match && st.pend_vld && !st.out_space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (st.in_op == OP_REPORT) ? ST_RPT : ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (st.mod_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.hit || st.miss)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (st.out_space)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RPT:
            begin
                if (rpt_go && st.rpt_last)
                begin
                    state_next = ST_RFIN;
                end
            end
            ST_RFIN:
            begin
                if (st.out_space)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != ST_IDLE);
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = req_valid;
            end
            ST_MOD:
            begin
                cmd.mod_step  = !st.mod_done;
                cmd.disp_init = st.mod_done;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_disp = st.out_space;
            end
            ST_RPT:
            begin
                cmd.rpt_step = rpt_go;
            end
            ST_RFIN:
            begin
                cmd.emit_final = st.out_space;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ src/rrd_datapath.sv @@
// ----------------------------------------------------------------------------
// rrd_datapath
// Server tables, scan counters, result register and the config register.
// ----------------------------------------------------------------------------
module rrd_datapath
    import rrd_pkg::*;
#(
    parameter int NUM_SERVERS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  st,
    input  req_item_t   req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_item_t   rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "round_robin_request_dispatcher_macros.svh"

    localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CW = $clog2(NUM_SERVERS + 1);

    logic [NS_W-1:0]    ns_reg;
    logic [NS_W-1:0]    k_raw;
    logic [CW-1:0]      k;

    logic               op_reg;
    logic [TIME_W-1:0]  arr_reg;
    logic [TIME_W-1:0]  svc_reg;
    logic [IW-1:0]      start_reg;
    logic [IW-1:0]      startpos_reg;
    logic [COUNT_W-1:0] max_reg;
    logic [IW-1:0]      pos_reg;
    logic [IW-1:0]      pos_next;
    logic [IW-1:0]      chk_reg;
    logic [CW-1:0]      issued_reg;
    logic [CW-1:0]      checked_reg;
    logic               rd_vld_reg;
    logic               rd_ok_reg;
    logic [BUSY_W-1:0]  rd_busy_reg;
    logic [COUNT_W-1:0] rd_cnt_reg;
    logic [NUM_SERVERS-1:0] valid_reg;

    logic [BUSY_W-1:0]  busy_ram [NUM_SERVERS];
    logic [COUNT_W-1:0] count_ram [NUM_SERVERS];

    logic               res_served_reg;
    logic [IW-1:0]      res_idx_reg;
    logic               pend_vld_reg;
    logic [IW-1:0]      pend_idx_reg;
    rsp_item_t          out_reg;
    logic               out_valid_reg;

    logic [BUSY_W-1:0]  cur_busy;
    logic [COUNT_W-1:0] cur_cnt;
    logic [COUNT_W-1:0] new_cnt;
    logic               free;
    logic               match;
    logic               final_check;
    logic               check;
    logic               issue;
    logic               wr_en;
    logic               out_space;
    logic               cfg_wr;
    logic [CW-1:0]      start_inc;

    // ---------------- config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_NUM_SERVERS);
    assign prdata = (paddr[2:2] == REG_NUM_SERVERS) ? {25'd0, ns_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg <= NUM_SERVERS_RESET;
        end
        else if (cfg_wr)
        begin
            ns_reg <= pwdata[NS_W-1:0];
        end
    end

    always_comb
    begin
        if (ns_reg == '0)
        begin
            k_raw = NS_W'(1);
        end
        else if (ns_reg > NS_W'(NUM_SERVERS))
        begin
            k_raw = NS_W'(NUM_SERVERS);
        end
        else
        begin
            k_raw = ns_reg;
        end
    end
    assign k = CW'(k_raw);

    // ---------------- entry evaluation
    assign cur_busy    = rd_ok_reg ? rd_busy_reg : '0;
    assign cur_cnt     = rd_ok_reg ? rd_cnt_reg  : '0;
    assign new_cnt     = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    assign free        = ({1'b0, arr_reg} >= cur_busy);
    assign match       = (cur_cnt == max_reg);
    assign final_check = rd_vld_reg && (checked_reg + 1'b1 == k);
    assign out_space   = !out_valid_reg || !rsp_stall;

    assign check = cmd.scan_step || cmd.rpt_step;
    assign issue = check && (issued_reg < k);
    assign wr_en = cmd.scan_step && rd_vld_reg && free;

    assign pos_next  = (CW'(pos_reg) + 1'b1 == k) ? '0 : IW'(CW'(pos_reg) + 1'b1);
    assign start_inc = CW'(start_reg) + 1'b1;

    always_comb
    begin
        st.in_op     = req_data.operation;
        st.mod_done  = (CW'(start_reg) < k);
        st.hit       = rd_vld_reg && free;
        st.miss      = final_check && !free;
        st.rpt_match = rd_vld_reg && match;
        st.rpt_last  = final_check;
        st.pend_vld  = pend_vld_reg;
        st.out_space = out_space;
    end

    // ---------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startpos_reg  <= '0;
            max_reg       <= '0;
            issued_reg    <= '0;
            checked_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            rd_ok_reg     <= 1'b0;
            valid_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                issued_reg   <= '0;
                checked_reg  <= '0;
                rd_vld_reg   <= 1'b0;
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    issued_reg <= issued_reg + 1'b1;
                    rd_ok_reg  <= valid_reg[pos_reg];
                    rd_vld_reg <= 1'b1;
                end
                else if (check)
                begin
                    rd_vld_reg <= 1'b0;
                end
                if (check && rd_vld_reg)
                begin
                    checked_reg <= checked_reg + 1'b1;
                end
                if (cmd.rpt_step && rd_vld_reg && match)
                begin
                    pend_vld_reg <= 1'b1;
                end
            end
            if (cmd.disp_init)
            begin
                startpos_reg <= (start_inc == k) ? '0 : IW'(start_inc);
            end
            if (wr_en)
            begin
                valid_reg[chk_reg] <= 1'b1;
                if (new_cnt > max_reg)
                begin
                    max_reg <= new_cnt;
                end
            end
            if (cmd.emit_disp || cmd.emit_final ||
                (cmd.rpt_step && rd_vld_reg && match && pend_vld_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers and tables
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req_data.operation;
            arr_reg   <= req_data.arrival_time;
            svc_reg   <= req_data.service_time;
            start_reg <= startpos_reg;
            pos_reg   <= '0;
        end
        if (cmd.mod_step)
        begin
            start_reg <= IW'(CW'(start_reg) - k);
        end
        if (cmd.disp_init)
        begin
            pos_reg <= start_reg;
        end
        if (issue)
        begin
            pos_reg     <= pos_next;
            chk_reg     <= pos_reg;
            rd_busy_reg <= busy_ram[pos_reg];
            rd_cnt_reg  <= count_ram[pos_reg];
        end
        if (wr_en)
        begin
            busy_ram[chk_reg]  <= {1'b0, arr_reg} + {1'b0, svc_reg};
            count_ram[chk_reg] <= new_cnt;
        end
        if (cmd.scan_step && rd_vld_reg)
        begin
            res_served_reg <= free;
            res_idx_reg    <= free ? chk_reg : '0;
        end
        if (cmd.rpt_step && rd_vld_reg && match)
        begin
            pend_idx_reg <= chk_reg;
            if (pend_vld_reg)
            begin
                out_reg <= '{served: 1'b1, server_index: SRV_IDX_W'(pend_idx_reg),
                             busiest_count: max_reg, last: 1'b0};
            end
        end
        if (cmd.emit_disp)
        begin
            out_reg <= '{served: res_served_reg, server_index: SRV_IDX_W'(res_idx_reg),
                         busiest_count: max_reg, last: 1'b1};
        end
        if (cmd.emit_final)
        begin
            out_reg <= '{served: pend_vld_reg,
                         server_index: pend_vld_reg ? SRV_IDX_W'(pend_idx_reg) : '0,
                         busiest_count: max_reg, last: 1'b1};
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // ---------------- assertions
    `RRD_ASSERT_IMPL(a_wr_in_pool, wr_en, (CW'(chk_reg) < k), "table write outside pool")
    `RRD_ASSERT_NEXT(a_max_mono, 1'b1, (max_reg >= $past(max_reg)), "max count decreased")
    `RRD_ASSERT_NEXT(a_start_in_pool, cmd.disp_init, (CW'(startpos_reg) < k),
                     "start position outside pool")
    `RRD_ASSERT_IMPL(a_check_le_issue, 1'b1, (checked_reg <= issued_reg),
                     "entry checked before read")
    `RRD_ASSERT_IMPL(a_dispatch_op, cmd.scan_step, (op_reg == OP_DISPATCH),
                     "scan on report request")

endmodule

@@ src/round_robin_request_dispatcher.sv @@
// ----------------------------------------------------------------------------
// round_robin_request_dispatcher
// Dispatch: start wrap subtractions (none unless num_servers was lowered), then
//   a scan that passes over busy servers, then the result.
// Report: scans the k servers in use. One request in flight at a time.
// One table read per cycle sets the scan pace, unless a report output stalls.
// Reset clears valid bits, so tables read as zero at once; no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_request_dispatcher
    import rrd_pkg::*;
#(
    parameter int NUM_SERVERS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_item_t   req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_item_t   rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    rrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    rrd_datapath #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the round-robin request dispatcher against a cycle-free predictor of
// the server pool. Requests go in through a queue-fed driver; every result is
// compared field by field with the oldest prediction. The server count is
// rewritten over APB between phases, once all results are back.
// ----------------------------------------------------------------------------
module tb_top;
    import rrd_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int unsigned POOL_SIZE    = 64;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES  = 150;
    localparam int unsigned REPORT_PCT   = 15;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    req_item_t   pending_reqs[$];
    rsp_item_t   expected_rsps[$];
    bit          req_fire = 1'b0;
    int unsigned idle_pct;
    int unsigned error_count = 0;
    logic [31:0] clock_now;

    // predictor state
    logic [NS_W-1:0]      servers_cfg;
    logic [BUSY_W-1:0]    busy_until[POOL_SIZE] = '{default: '0};
    logic [COUNT_W-1:0]   served_cnt[POOL_SIZE] = '{default: '0};
    logic [SRV_IDX_W-1:0] next_start = '0;
    logic [COUNT_W-1:0]   top_count = '0;

    round_robin_request_dispatcher #(
        .NUM_SERVERS (POOL_SIZE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned servers_in_use();
        int unsigned n;
        n = servers_cfg;
        if (n == 0)
            n = 1;
        if (n > POOL_SIZE)
            n = POOL_SIZE;
        return n;
    endfunction

    function automatic void dispatch_request(req_item_t r);
        int unsigned n;
        int unsigned first;
        int unsigned s;
        int unsigned i;
        bit          found;
        rsp_item_t   e;
        n     = servers_in_use();
        first = next_start % n;
        found = 1'b0;
        e     = '0;
        for (i = 0; i < n && !found; i++)
        begin
            s = (first + i) % n;
            if ({1'b0, r.arrival_time} >= busy_until[s])
            begin
                busy_until[s] = {1'b0, r.arrival_time} + {1'b0, r.service_time};
                if (served_cnt[s] != COUNT_MAX)
                    served_cnt[s] = served_cnt[s] + 1;
                if (served_cnt[s] > top_count)
                    top_count = served_cnt[s];
                e.served       = 1'b1;
                e.server_index = SRV_IDX_W'(s);
                found          = 1'b1;
            end
        end
        next_start      = SRV_IDX_W'((first + 1 == n) ? 0 : first + 1);
        e.busiest_count = top_count;
        e.last          = 1'b1;
        expected_rsps   = {expected_rsps, e};
    endfunction

    function automatic void report_busiest();
        int unsigned n;
        int unsigned s;
        int unsigned hits;
        int unsigned seen;
        rsp_item_t   e;
        n    = servers_in_use();
        hits = 0;
        seen = 0;
        e    = '0;
        e.busiest_count = top_count;
        for (s = 0; s < n; s++)
            if (served_cnt[s] == top_count)
                hits++;
        if (hits == 0)
        begin
            e.last        = 1'b1;
            expected_rsps = {expected_rsps, e};
        end
        for (s = 0; s < n; s++)
        begin
            if (served_cnt[s] == top_count)
            begin
                seen++;
                e.served       = 1'b1;
                e.server_index = SRV_IDX_W'(s);
                e.last         = (seen == hits);
                expected_rsps  = {expected_rsps, e};
            end
        end
    endfunction

    function automatic void check_result(rsp_item_t got);
        rsp_item_t exp_rsp;
        if (expected_rsps.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected result: served=%0d idx=%0d count=%0d last=%0d",
                         got.served, got.server_index, got.busiest_count, got.last);
            return;
        end
        exp_rsp = expected_rsps.pop_front();
        if (got.served !== exp_rsp.served || got.server_index !== exp_rsp.server_index
            || got.busiest_count !== exp_rsp.busiest_count || got.last !== exp_rsp.last)
        begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                         exp_rsp.served, exp_rsp.server_index, exp_rsp.busiest_count,
                         exp_rsp.last, got.served, got.server_index, got.busiest_count,
                         got.last);
        end
    endfunction

    // request driver and response stall, both on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_fire)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                req_data  <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
        rsp_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        req_fire = req_valid && !req_stall;
        if (req_fire)
        begin
            if (req_data.operation == OP_DISPATCH)
                dispatch_request(req_data);
            else
                report_busiest();
        end
        if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
    end

    function automatic req_item_t make_req(logic op, logic [31:0] arrival,
                                           logic [31:0] service);
        req_item_t r;
        r.operation    = op;
        r.arrival_time = arrival;
        r.service_time = service;
        return r;
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_servers(input logic [NS_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({REG_NUM_SERVERS, 2'b00});
        pwdata  <= {25'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        servers_cfg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [NS_W-1:0] ns_value, input int unsigned n_items,
                             input int unsigned idle_value, input bit wide_service);
        int unsigned i;
        int unsigned k;
        logic [31:0] service;
        wait_idle();
        write_num_servers(ns_value);
        idle_pct = idle_value;
        k = servers_in_use();
        pending_reqs = {pending_reqs, make_req(OP_REPORT, $urandom, $urandom)};
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < REPORT_PCT)
            begin
                pending_reqs = {pending_reqs, make_req(OP_REPORT, $urandom, $urandom)};
            end
            else
            begin
                clock_now = clock_now + $urandom_range(0, 8);
                if (wide_service && $urandom_range(99) < 5)
                    service = $urandom;
                else
                    service = $urandom_range(0, 8 * k);
                pending_reqs = {pending_reqs, make_req(OP_DISPATCH, clock_now, service)};
            end
        end
    endtask

    initial
    begin
        #6_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_pct    = 29;
        clock_now   = 32'd300;
        servers_cfg = NUM_SERVERS_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: fresh report, field extremes, fill the pool, then a drop
        pending_reqs = {pending_reqs, make_req(OP_REPORT, '1, '1)};
        pending_reqs = {pending_reqs, make_req(OP_DISPATCH, '0, '0)};
        pending_reqs = {pending_reqs, make_req(OP_DISPATCH, '0, 32'd5)};
        pending_reqs = {pending_reqs, make_req(OP_DISPATCH, '0, '1)};
        pending_reqs = {pending_reqs, make_req(OP_DISPATCH, '1, '1)};
        pending_reqs = {pending_reqs, make_req(OP_REPORT, '0, '0)};
        repeat (14)
            pending_reqs = {pending_reqs, make_req(OP_DISPATCH, 32'd100, 32'd1000)};
        pending_reqs = {pending_reqs, make_req(OP_DISPATCH, 32'd200, 32'd7)};
        pending_reqs = {pending_reqs, make_req(OP_REPORT, '0, '0)};

        run_phase(7'd64, 45, 0, 1'b0);
        run_phase(7'd0, 30, 29, 1'b0);
        run_phase(7'd127, 45, 29, 1'b0);
        run_phase(7'd5, 35, 29, 1'b0);
        run_phase(7'd1, 30, 29, 1'b0);
        run_phase(7'd100, 30, 29, 1'b0);
        run_phase(7'd33, 35, 29, 1'b0);
        run_phase(7'd3, 30, 29, 1'b0);
        wait_idle();
        clock_now = $urandom_range(32'h8000_0000, 32'hFFFF_0000);
        run_phase(7'd64, 45, 29, 1'b1);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/rrd_pkg.sv
src/rrd_ctrl.sv
src/rrd_datapath.sv
src/round_robin_request_dispatcher.sv
dv/tb_top.sv
